[sv/assert_macros.svh]
// assertion macros for the checker file
// clocked on i_clk, with and without the reset guard
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// property checked through reset as well
`define ASSERT_CLK_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");

`endif

[sv/ibb_pkg.sv]
// shared types and register codes for the iterated box blur
// no dependencies
`timescale 1ns / 1ps

package ibb_pkg;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PASSES = 2'd2;

    localparam int unsigned CFG_DW = 9;

endpackage

[sv/ibb_ram.sv]
// single write port, single read port image store with registered read
// no dependencies
`timescale 1ns / 1ps

module ibb_ram #(
    parameter int unsigned AW = 16,
    parameter int unsigned DW = 24
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/ibb_div.sv]
// three-lane restoring divider, one quotient bit per cycle
// depends on ibb_pkg for the pixel type
`timescale 1ns / 1ps

module ibb_div #(
    parameter int unsigned SW = 14,
    parameter int unsigned NW = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SW-1:0]    i_sum_r,
    input  logic [SW-1:0]    i_sum_g,
    input  logic [SW-1:0]    i_sum_b,
    input  logic [NW-1:0]    i_count,
    output logic             o_done,
    output ibb_pkg::t_rgb    o_mean
);
    import ibb_pkg::*;

    localparam int unsigned CNTW = $clog2(SW + 1);

    logic [SW-1:0]   r_quo [3];
    logic [NW:0]     r_rem [3];
    logic [NW-1:0]   r_den;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [SW-1:0]   n_quo [3];
    logic [NW:0]     n_rem [3];

    always_comb begin
        logic [NW+1:0] trial;
        trial = '0;
        for (int i = 0; i < 3; i++) begin
            trial = {r_rem[i], r_quo[i][SW-1]};
            if (trial >= {2'b00, r_den}) begin
                trial = trial - {2'b00, r_den};
                n_quo[i] = {r_quo[i][SW-2:0], 1'b1};
            end else begin
                n_quo[i] = {r_quo[i][SW-2:0], 1'b0};
            end
            n_rem[i] = trial[NW:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_cnt    <= '0;
                r_den    <= i_count;
                r_quo[0] <= i_sum_r;
                r_quo[1] <= i_sum_g;
                r_quo[2] <= i_sum_b;
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= '0;
                end
            end else if (r_busy) begin
                for (int i = 0; i < 3; i++) begin
                    r_quo[i] <= n_quo[i];
                    r_rem[i] <= n_rem[i];
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(SW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_mean.r = r_quo[0][7:0];
    assign o_mean.g = r_quo[1][7:0];
    assign o_mean.b = r_quo[2][7:0];

endmodule

[sv/iterated_box_blur_7x7.sv]
// top level of the iterated box blur: load, blur sequencer and read-back
// depends on ibb_pkg, ibb_ram and ibb_div
`timescale 1ns / 1ps
//
// Input stream: tuser is the mode, 0 loads tdata as one pixel in raster
// order, 1 requests the next blurred pixel. The load that completes the
// region (width x height pixels) starts the blur if passes is nonzero,
// and the block holds o_s_tready low until all passes are done.
// Each blurred pixel walks its (2R+1)^2 window taps through the store read
// port, one tap a cycle, then a restoring divider gives the three channel
// means in one bit a cycle; the taps of the next pixel start only once the
// divider is done.
// A read request goes through the store read register and the S_RD state
// into the output register; a read while a region is half loaded yields
// no word. The output word is registered, and while the receiver stalls
// it holds and no new item is taken. Configuration writes are taken at
// any time and should be made only while idle.
// Reset (synchronous, active low) returns the registers to 16, 16 and 1
// and clears the indices; the image stores are not cleared.
//

module iterated_box_blur_7x7 #(
    parameter int unsigned MAX_WIDTH     = 256,
    parameter int unsigned MAX_HEIGHT    = 256,
    parameter int unsigned KERNEL_RADIUS = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [23:0]                 i_s_tdata,   // pixel_in
    input  logic                        i_s_tuser,   // mode
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [23:0]                 o_m_tdata,   // pixel_out
    output logic                        o_m_tlast,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [ibb_pkg::CFG_DW-1:0]  i_cfg_data
);
    import ibb_pkg::*;

    localparam int unsigned MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int unsigned DW    = $clog2(MAXD + 1);
    localparam int unsigned CW    = DW + 2;
    localparam int unsigned AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int unsigned IW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int unsigned TAPS  = (2 * KERNEL_RADIUS + 1) * (2 * KERNEL_RADIUS + 1);
    localparam int unsigned SW    = $clog2(TAPS * 255 + 1);
    localparam int unsigned NW    = $clog2(TAPS + 1);
    localparam int unsigned KW    = $clog2(KERNEL_RADIUS + 1) + 1;
    localparam logic signed [KW-1:0] KR  = KW'(KERNEL_RADIUS);
    localparam logic signed [KW-1:0] KRN = -KW'(KERNEL_RADIUS);

    typedef enum logic [1:0] {S_IDLE, S_RD, S_TAP, S_WAIT} t_state;

    t_state r_state;

    logic [CFG_DW-1:0] r_width;
    logic [CFG_DW-1:0] r_height;
    logic [3:0]        r_passes;

    logic [IW-1:0] r_load_idx;
    logic [IW-1:0] r_read_idx;
    logic          r_res_b;

    logic [3:0]    r_pass;
    logic          r_src_b;
    logic [DW-1:0] r_px;
    logic [DW-1:0] r_py;
    logic [AW-1:0] r_pix_idx;
    logic signed [KW-1:0] r_kx;
    logic signed [KW-1:0] r_ky;

    logic          r_s1_v;
    logic          r_s1_last;
    logic [AW-1:0] r_s1_addr;
    logic          r_s2_v;
    logic          r_s2_last;

    logic [SW-1:0] r_sum_r;
    logic [SW-1:0] r_sum_g;
    logic [SW-1:0] r_sum_b;
    logic [NW-1:0] r_cnt;

    logic          r_oval;
    logic [23:0]   r_odata;
    logic          r_olast;

    logic [DW-1:0]   w_eff;
    logic [DW-1:0]   h_eff;
    logic [IW-1:0]   count;
    logic [2*DW-1:0] count_full;
    logic            s_acc;
    logic            is_load;
    logic [IW-1:0]   lidx;
    logic [IW-1:0]   ridx;
    logic [IW-1:0]   n_load_idx;
    logic [IW-1:0]   n_read_idx;

    logic signed [CW-1:0] c_xx;
    logic signed [CW-1:0] c_yy;
    logic                 c_in;
    logic [2*DW-1:0]      c_row;
    logic [AW-1:0]        c_addr;
    logic                 c_last;

    logic [23:0]   rd_a;
    logic [23:0]   rd_b;
    logic [23:0]   src_data;
    logic [AW-1:0] rd_addr;
    logic          we_a;
    logic          we_b;
    logic [AW-1:0] wa_a;
    logic [AW-1:0] wa_b;
    logic [23:0]   wd_a;
    logic [23:0]   wd_b;

    logic [SW-1:0] n_sum_r;
    logic [SW-1:0] n_sum_g;
    logic [SW-1:0] n_sum_b;
    logic [NW-1:0] n_cnt;

    logic          div_done;
    t_rgb          div_mean;

    // effective region size
    always_comb begin
        if (r_width == '0) begin
            w_eff = DW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = DW'(MAX_WIDTH);
        end else begin
            w_eff = DW'(r_width);
        end
        if (r_height == '0) begin
            h_eff = DW'(1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            h_eff = DW'(MAX_HEIGHT);
        end else begin
            h_eff = DW'(r_height);
        end
    end

    assign count_full = w_eff * h_eff;
    assign count      = IW'(count_full);

    assign o_s_tready = (r_state == S_IDLE) && (!r_oval || i_m_tready);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign is_load    = !i_s_tuser;
    assign o_cfg_ready = 1'b1;

    assign lidx       = (r_load_idx >= count) ? '0 : r_load_idx;
    assign ridx       = (r_read_idx >= count) ? '0 : r_read_idx;
    assign n_load_idx = lidx + 1'b1;
    assign n_read_idx = (ridx + 1'b1 >= count) ? '0 : ridx + 1'b1;

    // window tap coordinates and store address
    assign c_xx   = $signed({2'b00, r_px}) + CW'(r_kx);
    assign c_yy   = $signed({2'b00, r_py}) + CW'(r_ky);
    assign c_in   = (c_xx >= 0) && (c_xx < $signed({2'b00, w_eff}))
                 && (c_yy >= 0) && (c_yy < $signed({2'b00, h_eff}));
    assign c_row  = c_yy[DW-1:0] * w_eff;
    assign c_addr = AW'(c_row) + AW'(c_xx[DW-1:0]);
    assign c_last = (r_kx == KR) && (r_ky == KR);

    assign rd_addr  = (r_state == S_IDLE) ? ridx[AW-1:0] : r_s1_addr;
    assign src_data = r_src_b ? rd_b : rd_a;

    // store writes: loads into a, blur results into the other store
    always_comb begin
        we_a = 1'b0;
        we_b = 1'b0;
        wa_a = r_pix_idx;
        wa_b = r_pix_idx;
        wd_a = div_mean;
        wd_b = div_mean;
        if (s_acc && is_load) begin
            we_a = 1'b1;
            wa_a = lidx[AW-1:0];
            wd_a = i_s_tdata;
        end else if ((r_state == S_WAIT) && div_done) begin
            we_a = r_src_b;
            we_b = !r_src_b;
        end
    end

    // tap accumulation
    always_comb begin
        n_sum_r = r_sum_r;
        n_sum_g = r_sum_g;
        n_sum_b = r_sum_b;
        n_cnt   = r_cnt;
        if (r_s2_v) begin
            n_sum_r = r_sum_r + SW'(src_data[23:16]);
            n_sum_g = r_sum_g + SW'(src_data[15:8]);
            n_sum_b = r_sum_b + SW'(src_data[7:0]);
            n_cnt   = r_cnt + 1'b1;
        end
    end

    ibb_ram #(.AW(AW), .DW(24)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (wa_a),
        .i_wdata (wd_a),
        .i_raddr (rd_addr),
        .o_rdata (rd_a)
    );

    ibb_ram #(.AW(AW), .DW(24)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (wa_b),
        .i_wdata (wd_b),
        .i_raddr (rd_addr),
        .o_rdata (rd_b)
    );

    ibb_div #(.SW(SW), .NW(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_s2_last),
        .i_sum_r (n_sum_r),
        .i_sum_g (n_sum_g),
        .i_sum_b (n_sum_b),
        .i_count (n_cnt),
        .o_done  (div_done),
        .o_mean  (div_mean)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_width    <= CFG_DW'(16);
            r_height   <= CFG_DW'(16);
            r_passes   <= 4'd1;
            r_load_idx <= '0;
            r_read_idx <= '0;
            r_res_b    <= 1'b0;
            r_pass     <= '0;
            r_src_b    <= 1'b0;
            r_s1_v     <= 1'b0;
            r_s1_last  <= 1'b0;
            r_s2_v     <= 1'b0;
            r_s2_last  <= 1'b0;
            r_sum_r    <= '0;
            r_sum_g    <= '0;
            r_sum_b    <= '0;
            r_cnt      <= '0;
            r_oval     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data;
                    REG_PASSES: r_passes <= i_cfg_data[3:0];
                    default: ;
                endcase
            end

            if (r_oval && i_m_tready) begin
                r_oval <= 1'b0;
            end

            // tap pipeline: address, store read, accumulate
            r_s1_v    <= 1'b0;
            r_s1_last <= 1'b0;
            r_s2_v    <= r_s1_v;
            r_s2_last <= r_s1_last;
            if (r_s2_last) begin
                r_sum_r <= '0;
                r_sum_g <= '0;
                r_sum_b <= '0;
                r_cnt   <= '0;
            end else begin
                r_sum_r <= n_sum_r;
                r_sum_g <= n_sum_g;
                r_sum_b <= n_sum_b;
                r_cnt   <= n_cnt;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        if (is_load) begin
                            if (n_load_idx == count) begin
                                r_load_idx <= '0;
                                r_read_idx <= '0;
                                r_res_b    <= r_passes[0];
                                if (r_passes != '0) begin
                                    r_pass    <= '0;
                                    r_src_b   <= 1'b0;
                                    r_px      <= '0;
                                    r_py      <= '0;
                                    r_pix_idx <= '0;
                                    r_kx      <= KRN;
                                    r_ky      <= KRN;
                                    r_state   <= S_TAP;
                                end
                            end else begin
                                r_load_idx <= n_load_idx;
                            end
                        end else if (r_load_idx == '0) begin
                            r_olast    <= (ridx == count - 1'b1);
                            r_read_idx <= n_read_idx;
                            r_state    <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_oval  <= 1'b1;
                    r_odata <= r_res_b ? rd_b : rd_a;
                    r_state <= S_IDLE;
                end
                S_TAP: begin
                    r_s1_v    <= c_in;
                    r_s1_last <= c_last;
                    r_s1_addr <= c_addr;
                    if (r_kx == KR) begin
                        r_kx <= KRN;
                        r_ky <= r_ky + 1'b1;
                    end else begin
                        r_kx <= r_kx + 1'b1;
                    end
                    if (c_last) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (div_done) begin
                        r_pix_idx <= r_pix_idx + 1'b1;
                        r_kx      <= KRN;
                        r_ky      <= KRN;
                        r_state   <= S_TAP;
                        if (r_px == w_eff - 1'b1) begin
                            r_px <= '0;
                            if (r_py == h_eff - 1'b1) begin
                                r_py      <= '0;
                                r_pix_idx <= '0;
                                r_src_b   <= !r_src_b;
                                r_pass    <= r_pass + 1'b1;
                                if (r_pass + 1'b1 == r_passes) begin
                                    r_state <= S_IDLE;
                                end
                            end else begin
                                r_py <= r_py + 1'b1;
                            end
                        end else begin
                            r_px <= r_px + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_oval;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

endmodule

[sv/ibb_checker.sv]
// port-level checks for the iterated box blur, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ibb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tlast
);

    // a stalled word holds
    `ASSERT_CLK(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))

    // a word appears only after an accepted read request
    `ASSERT_CLK(a_out_cause, $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready && i_s_tuser, 2))

    // no new item while a word is stalled
    `ASSERT_CLK(a_stall_block, o_m_tvalid && !i_m_tready |-> !o_s_tready)

    // reset empties the output
    `ASSERT_CLK_ALWAYS(a_reset_empty, !i_rst_n |=> !o_m_tvalid)

endmodule

bind iterated_box_blur_7x7 ibb_checker u_ibb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
